@@ rtl/tls_certificate_handshake_tracker_assert.svh @@
// assertion macros for the tls certificate handshake tracker
// needs a clk_i / rst_ni pair in the scope where a macro is used
`ifndef TLS_CERTIFICATE_HANDSHAKE_TRACKER_ASSERT_SVH
`define TLS_CERTIFICATE_HANDSHAKE_TRACKER_ASSERT_SVH

// same-cycle implication
`define TLSCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlsct_pkg.sv @@
// shared types and constants of the tls certificate handshake tracker
// no dependencies
`timescale 1ns / 1ps

package tlsct_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned LenW           = 24;
  localparam int unsigned RecLenW        = 15;
  localparam int unsigned StatusW        = 2;
  localparam int unsigned OutDataW       = 8;

  localparam logic [ByteW-1:0]   RecTypeHandshake = 8'd22;
  localparam logic [ByteW-1:0]   TlsVersionByte   = 8'd3;
  localparam logic [ByteW-1:0]   MsgTypeCert      = 8'd11;
  localparam logic [15:0]        MaxRecordPayload = 16'd16384;
  localparam logic [LenW-1:0]    CertMaxReset     = 24'd16384;
  localparam logic [LenW-1:0]    CertMinLen       = 24'd6;
  localparam logic [LenW-1:0]    LenFieldBytes    = 24'd3;

  // last index of the record header (5 bytes) and message header (4 bytes)
  localparam logic [2:0]         RecHdrLast       = 3'd4;
  localparam logic [1:0]         MsgHdrLast       = 2'd3;

  // offsets inside the certificate body
  localparam logic [2:0]         OffListLast      = 3'd2;
  localparam logic [2:0]         OffEntryLast     = 3'd5;
  localparam logic [2:0]         OffListEnd       = 3'd3;
  localparam logic [2:0]         OffEntryEnd      = 3'd6;

  typedef enum logic [StatusW-1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_FAIL = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
  } step_t;

endpackage

@@ rtl/tlsct_parser.sv @@
// record and handshake parser state of the certificate tracker, one byte per step
// depends on tlsct_pkg
`timescale 1ns / 1ps

module tlsct_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlsct_pkg::step_t              step_i,
  input  logic [tlsct_pkg::LenW-1:0]    cert_max_len_i,
  output tlsct_pkg::status_e            status_o
);

  logic [tlsct_pkg::ByteW-1:0]   rec_hdr_q [4];
  logic [tlsct_pkg::ByteW-1:0]   rec_hdr_d [4];
  logic [2:0]                    rec_cnt_q, rec_cnt_d;
  logic [tlsct_pkg::RecLenW-1:0] rec_left_q, rec_left_d;
  logic [tlsct_pkg::ByteW-1:0]   msg_hdr_q [3];
  logic [tlsct_pkg::ByteW-1:0]   msg_hdr_d [3];
  logic [1:0]                    msg_cnt_q, msg_cnt_d;
  logic [tlsct_pkg::LenW-1:0]    msg_len_q, msg_len_d;
  logic [tlsct_pkg::LenW-1:0]    msg_left_q, msg_left_d;
  logic                          in_cert_q, in_cert_d;
  logic [2:0]                    body_q, body_d;
  logic [tlsct_pkg::LenW-1:0]    list_q, list_d;
  logic [tlsct_pkg::LenW-1:0]    entry_q, entry_d;
  logic                          done_q, done_d;
  logic                          failed_q, failed_d;

  logic [tlsct_pkg::ByteW-1:0]   b;
  logic [15:0]                   rec_len;
  logic [tlsct_pkg::LenW-1:0]    hdr_len;
  logic [tlsct_pkg::LenW-1:0]    list_new;
  logic [tlsct_pkg::LenW-1:0]    entry_new;
  logic [tlsct_pkg::LenW:0]      list_plus3;
  logic                          hdr_is_cert;
  logic                          fail_now;

  assign b          = step_i.data_byte;
  assign rec_len    = {rec_hdr_q[3], b};
  assign hdr_len    = {msg_hdr_q[1], msg_hdr_q[2], b};
  assign hdr_is_cert = (msg_hdr_q[0] == tlsct_pkg::MsgTypeCert);
  assign list_new   = {list_q[15:0], b};
  assign entry_new  = {entry_q[15:0], b};
  assign list_plus3 = {1'b0, list_new} + {1'b0, tlsct_pkg::LenFieldBytes};

  always_comb begin
    rec_hdr_d  = rec_hdr_q;
    rec_cnt_d  = rec_cnt_q;
    rec_left_d = rec_left_q;
    msg_hdr_d  = msg_hdr_q;
    msg_cnt_d  = msg_cnt_q;
    msg_len_d  = msg_len_q;
    msg_left_d = msg_left_q;
    in_cert_d  = in_cert_q;
    body_d     = body_q;
    list_d     = list_q;
    entry_d    = entry_q;
    done_d     = done_q;
    failed_d   = failed_q;
    fail_now   = 1'b0;

    if (step_i.valid && !failed_q && !done_q) begin
      if (rec_left_q == '0) begin
        // collecting the record header
        if (rec_cnt_q != tlsct_pkg::RecHdrLast) begin
          rec_hdr_d[rec_cnt_q[1:0]] = b;
          rec_cnt_d = rec_cnt_q + 3'd1;
        end else begin
          rec_cnt_d = '0;
          if (rec_hdr_q[0] != tlsct_pkg::RecTypeHandshake ||
              rec_hdr_q[1] != tlsct_pkg::TlsVersionByte ||
              rec_hdr_q[2] != tlsct_pkg::TlsVersionByte) begin
            failed_d = 1'b1;
          end else if (rec_len == '0 || rec_len > tlsct_pkg::MaxRecordPayload) begin
            failed_d = 1'b1;
          end else begin
            rec_left_d = rec_len[tlsct_pkg::RecLenW-1:0];
          end
        end
      end else begin
        if (msg_left_q == '0) begin
          // handshake header, may straddle records
          if (msg_cnt_q != tlsct_pkg::MsgHdrLast) begin
            msg_hdr_d[msg_cnt_q] = b;
            msg_cnt_d = msg_cnt_q + 2'd1;
          end else begin
            msg_cnt_d  = '0;
            msg_len_d  = hdr_len;
            msg_left_d = hdr_len;
            in_cert_d  = hdr_is_cert;
            if (hdr_is_cert) begin
              if (hdr_len < tlsct_pkg::CertMinLen) begin
                fail_now = 1'b1;
              end else begin
                body_d  = '0;
                list_d  = '0;
                entry_d = '0;
              end
            end
          end
        end else begin
          if (in_cert_q) begin
            if (body_q < tlsct_pkg::OffListEnd) begin
              list_d = list_new;
              if (body_q == tlsct_pkg::OffListLast &&
                  (list_new < tlsct_pkg::LenFieldBytes ||
                   {1'b0, msg_len_q} != list_plus3)) begin
                fail_now = 1'b1;
              end
            end else if (body_q < tlsct_pkg::OffEntryEnd) begin
              entry_d = entry_new;
              if (body_q == tlsct_pkg::OffEntryLast &&
                  (entry_new == '0 || entry_new > cert_max_len_i ||
                   entry_new != list_q - tlsct_pkg::LenFieldBytes)) begin
                fail_now = 1'b1;
              end
            end
            // offset only matters up to the end of the entry length
            if (body_q < tlsct_pkg::OffEntryEnd) begin
              body_d = body_q + 3'd1;
            end
          end
          if (!fail_now) begin
            msg_left_d = msg_left_q - 24'd1;
            if (msg_left_q == 24'd1 && in_cert_q) begin
              done_d    = 1'b1;
              in_cert_d = 1'b0;
            end
          end
        end
        if (fail_now) begin
          failed_d = 1'b1;
        end else begin
          rec_left_d = rec_left_q - 15'd1;
        end
      end
    end
  end

  always_comb begin
    if (failed_d) begin
      status_o = tlsct_pkg::STATUS_FAIL;
    end else if (done_d) begin
      status_o = tlsct_pkg::STATUS_DONE;
    end else begin
      status_o = tlsct_pkg::STATUS_BUSY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_hdr_q  <= '{default: '0};
      rec_cnt_q  <= '0;
      rec_left_q <= '0;
      msg_hdr_q  <= '{default: '0};
      msg_cnt_q  <= '0;
      msg_len_q  <= '0;
      msg_left_q <= '0;
      in_cert_q  <= 1'b0;
      body_q     <= '0;
      list_q     <= '0;
      entry_q    <= '0;
      done_q     <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      rec_hdr_q  <= rec_hdr_d;
      rec_cnt_q  <= rec_cnt_d;
      rec_left_q <= rec_left_d;
      msg_hdr_q  <= msg_hdr_d;
      msg_cnt_q  <= msg_cnt_d;
      msg_len_q  <= msg_len_d;
      msg_left_q <= msg_left_d;
      in_cert_q  <= in_cert_d;
      body_q     <= body_d;
      list_q     <= list_d;
      entry_q    <= entry_d;
      done_q     <= done_d;
      failed_q   <= failed_d;
    end
  end

endmodule

@@ rtl/tls_certificate_handshake_tracker.sv @@
// top level of the tls certificate handshake tracker: stream ports, config register
// depends on tlsct_pkg, tlsct_parser and tls_certificate_handshake_tracker_assert.svh
`timescale 1ns / 1ps

// Watches a TLS 1.2 byte stream one byte per request and returns one status per byte:
// 0 in progress, 1 certificate message complete, 2 failure (sticky). Record headers
// must be handshake type, version 3.3, length 1..16384; the first certificate message
// has its list and single entry lengths checked, the entry against cert max length
// (cfg_wdata_i, reset 16384). The block takes one byte every cycle while the output is
// drained; the status of a byte is offered once it has passed the input register and
// then the status register, the whole parser step done combinationally between the two.
// With the output held, one byte waits in each register before the input stalls.
module tls_certificate_handshake_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tlsct_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tlsct_pkg::OutDataW-1:0] m_axis_tdata,  // [1:0] status, rest zero
  input  logic                          cfg_we_i,
  input  logic [tlsct_pkg::LenW-1:0]    cfg_wdata_i
);

  logic                          in_valid_q;
  logic [tlsct_pkg::ByteW-1:0]   in_byte_q;
  logic                          out_valid_q;
  tlsct_pkg::status_e            out_status_q;
  tlsct_pkg::status_e            step_status;
  logic [tlsct_pkg::LenW-1:0]    cert_max_q;
  logic                          advance;
  tlsct_pkg::step_t              step;

  // the input byte moves on once the status slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign step.valid     = advance;
  assign step.data_byte = in_byte_q;

  tlsct_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cert_max_len_i (cert_max_q),
    .status_o       (step_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cert_max_q <= tlsct_pkg::CertMaxReset;
    end else if (cfg_we_i) begin
      cert_max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= tlsct_pkg::STATUS_BUSY;
    end else if (advance) begin
      out_valid_q  <= 1'b1;
      out_status_q <= step_status;
    end else if (m_axis_tready) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(tlsct_pkg::OutDataW - tlsct_pkg::StatusW){1'b0}}, out_status_q};

`include "tls_certificate_handshake_tracker_assert.svh"

  // a failure reported once stays reported
  `TLSCT_ASSERT_NEXT(a_fail_sticky, advance && out_valid_q && out_status_q == tlsct_pkg::STATUS_FAIL, out_status_q == tlsct_pkg::STATUS_FAIL, "failure status was not sticky")

  // completion is only left toward nothing: bytes after it are ignored
  `TLSCT_ASSERT_NEXT(a_done_sticky, advance && out_valid_q && out_status_q == tlsct_pkg::STATUS_DONE, out_status_q == tlsct_pkg::STATUS_DONE, "complete status changed")

  // a byte waiting in the input register is not overwritten
  `TLSCT_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "pending input byte lost")

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the tls certificate handshake tracker
// drives a byte stream of records and handshake messages, checks each status against a
// byte-level tracker model kept here; depends on tlsct_pkg and the tracker rtl
`timescale 1ns / 1ps

module tb_top;
  import tlsct_pkg::*;

  // how the stream ends: one sticky outcome per run, picked at random
  typedef enum int {
    END_COMPLETE,
    END_BAD_TYPE,
    END_BAD_VERSION,
    END_ZERO_LEN,
    END_LONG_RECORD,
    END_SHORT_CERT,
    END_BAD_LIST,
    END_BAD_ENTRY
  } ending_e;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    status_e    status;
  } dir_row_t;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;
  localparam int RandomItems   = 1450;
  localparam logic [LenW-1:0] CertMaxTop = 24'hFFFFFF;

  // record of one byte, an empty message, a message header split over a record
  // boundary and a skipped two-byte body
  localparam dir_row_t DirTable [25] = '{
    '{8'd22, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY},
    '{8'h00, 1'b1, STATUS_BUSY}, '{8'h01, 1'b1, STATUS_BUSY},
    '{8'h00, 1'b1, STATUS_BUSY},
    '{8'd22, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY},
    '{8'h00, 1'b1, STATUS_BUSY}, '{8'h07, 1'b1, STATUS_BUSY},
    '{8'h00, 1'b1, STATUS_BUSY}, '{8'h00, 1'b1, STATUS_BUSY}, '{8'h00, 1'b1, STATUS_BUSY},
    '{8'hFF, 1'b1, STATUS_BUSY}, '{8'h00, 1'b1, STATUS_BUSY}, '{8'h00, 1'b1, STATUS_BUSY},
    '{8'h02, 1'b1, STATUS_BUSY},
    '{8'd22, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY}, '{8'd3, 1'b1, STATUS_BUSY},
    '{8'h00, 1'b1, STATUS_BUSY}, '{8'h02, 1'b1, STATUS_BUSY},
    '{8'hAA, 1'b1, STATUS_BUSY}, '{8'h55, 1'b1, STATUS_BUSY}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [LenW-1:0]  cfg_wdata_i = '0;

  tls_certificate_handshake_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // tracker model state
  logic [LenW-1:0]    cert_max = CertMaxReset;
  logic [7:0]         rec_hdr [5] = '{default: 8'h00};
  int                 rec_hdr_cnt = 0;
  logic [RecLenW-1:0] rec_left = '0;
  logic [7:0]         msg_hdr [4] = '{default: 8'h00};
  int                 msg_hdr_cnt = 0;
  logic [LenW-1:0]    msg_len = '0;
  logic [LenW-1:0]    msg_left = '0;
  logic               cert_active = 1'b0;
  logic [LenW-1:0]    cert_off = '0;
  logic [LenW-1:0]    list_len = '0;
  logic [LenW-1:0]    entry_len = '0;
  logic               cert_done = 1'b0;
  logic               hs_failed = 1'b0;

  status_e    status_due_q [$];
  logic [7:0] hs_q [$];
  int         items_sent = 0;
  int         results_taken = 0;
  int         err_cnt = 0;
  int         idle_cycles = 0;
  bit         in_burst = 1'b0;
  bit         typed_on = 1'b0;
  status_e    typed_status = STATUS_BUSY;

  function automatic void rec_header_byte(input logic [7:0] b);
    logic [15:0] len;
    rec_hdr[rec_hdr_cnt] = b;
    rec_hdr_cnt++;
    if (rec_hdr_cnt < 5) return;
    rec_hdr_cnt = 0;
    if (rec_hdr[0] != RecTypeHandshake || rec_hdr[1] != TlsVersionByte ||
        rec_hdr[2] != TlsVersionByte) begin
      hs_failed = 1'b1;
      return;
    end
    len = {rec_hdr[3], rec_hdr[4]};
    if (len == 16'd0 || len > MaxRecordPayload) begin
      hs_failed = 1'b1;
      return;
    end
    rec_left = len[RecLenW-1:0];
  endfunction

  function automatic void msg_header_byte(input logic [7:0] b);
    msg_hdr[msg_hdr_cnt] = b;
    msg_hdr_cnt++;
    if (msg_hdr_cnt < 4) return;
    msg_hdr_cnt = 0;
    msg_len = {msg_hdr[1], msg_hdr[2], msg_hdr[3]};
    msg_left = msg_len;
    cert_active = (msg_hdr[0] == MsgTypeCert);
    if (!cert_active) return;
    if (msg_len < CertMinLen) begin
      hs_failed = 1'b1;
      return;
    end
    cert_off = '0;
    list_len = '0;
    entry_len = '0;
  endfunction

  function automatic void cert_byte(input logic [7:0] b);
    if (cert_off < 3) begin
      list_len = {list_len[15:0], b};
      if (cert_off == 2 &&
          (list_len < LenFieldBytes || 32'(msg_len) != 32'(list_len) + 32'd3)) begin
        hs_failed = 1'b1;
        return;
      end
    end else if (cert_off < 6) begin
      entry_len = {entry_len[15:0], b};
      if (cert_off == 5 &&
          (entry_len == '0 || entry_len > cert_max || entry_len != list_len - LenFieldBytes))
      begin
        hs_failed = 1'b1;
        return;
      end
    end
    cert_off = cert_off + 1'b1;
  endfunction

  function automatic void payload_byte(input logic [7:0] b);
    if (msg_left == '0) begin
      msg_header_byte(b);
    end else begin
      if (cert_active) begin
        cert_byte(b);
        if (hs_failed) return;
      end
      msg_left = msg_left - 1'b1;
      if (msg_left == '0) begin
        if (cert_active) begin
          cert_done = 1'b1;
          cert_active = 1'b0;
        end else begin
          msg_hdr_cnt = 0;
        end
      end
    end
    if (hs_failed) return;
    rec_left = rec_left - 1'b1;
    if (rec_left == '0) rec_hdr_cnt = 0;
  endfunction

  function automatic status_e track_byte(input logic [7:0] b);
    if (!hs_failed && !cert_done) begin
      if (rec_left == '0) rec_header_byte(b);
      else payload_byte(b);
    end
    if (hs_failed) return STATUS_FAIL;
    if (cert_done) return STATUS_DONE;
    return STATUS_BUSY;
  endfunction

  // scoreboard and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    status_e    st;
    logic [7:0] want;
    if (rst_ni) begin
      if (cfg_we_i) cert_max = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        st = track_byte(s_axis_tdata);
        status_due_q.push_back(typed_on ? typed_status : st);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: status %0d with no request pending", $time, m_axis_tdata);
        end else begin
          want = {6'b0, status_due_q.pop_front()};
          if (m_axis_tdata !== want) begin
            err_cnt++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want, m_axis_tdata);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (items_sent % 64 == 0) in_burst = ($urandom_range(0, 3) == 0);
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // register writes only once every pending status has come back
  task automatic write_max(input logic [LenW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (status_due_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [LenW-1:0] pick_max();
    case ($urandom_range(0, 2))
      0:       return 24'd1;
      1:       return CertMaxTop;
      default: return LenW'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  task automatic push_rec_header(input int len);
    push_byte(RecTypeHandshake);
    push_byte(TlsVersionByte);
    push_byte(TlsVersionByte);
    push_byte(8'(len >> 8));
    push_byte(8'(len));
  endtask

  function automatic void add_other_msg();
    logic [7:0] kind;
    int         len;
    do kind = 8'($urandom_range(0, 255)); while (kind == MsgTypeCert);
    len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 30);
    hs_q.push_back(kind);
    hs_q.push_back(8'(len >> 16));
    hs_q.push_back(8'(len >> 8));
    hs_q.push_back(8'(len));
    repeat (len) hs_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_cert(input int mlen, input int llen, input int elen,
                                   input int body);
    hs_q.push_back(MsgTypeCert);
    hs_q.push_back(8'(mlen >> 16));
    hs_q.push_back(8'(mlen >> 8));
    hs_q.push_back(8'(mlen));
    hs_q.push_back(8'(llen >> 16));
    hs_q.push_back(8'(llen >> 8));
    hs_q.push_back(8'(llen));
    hs_q.push_back(8'(elen >> 16));
    hs_q.push_back(8'(elen >> 8));
    hs_q.push_back(8'(elen));
    repeat (body) hs_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // chop the handshake bytes into records; an open end declares the largest
  // record for the last one and leaves it short
  task automatic send_records(input bit open_end);
    int n;
    int r;
    while (hs_q.size() > 0) begin
      r = $urandom_range(0, 9);
      if (r == 0)      n = 1;
      else if (r < 8)  n = $urandom_range(1, 24);
      else if (r == 8) n = $urandom_range(25, 200);
      else             n = hs_q.size();
      if (n > hs_q.size()) n = hs_q.size();
      push_rec_header((open_end && n == hs_q.size()) ? int'(MaxRecordPayload) : n);
      repeat (n) push_byte(hs_q.pop_front());
    end
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int stall;
    bit burst;
    bit held;
    burst = 1'b0;
    held  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 8);
      if (!held && results_taken >= 200) begin
        held  = 1'b1;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      results_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    ending_e ending;
    int      e;
    int      m;
    int      l;
    int      lst;
    logic [7:0] a;
    logic [7:0] v;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_max(CertMaxTop);

    foreach (DirTable[i]) begin
      typed_on     = DirTable[i].typed;
      typed_status = DirTable[i].status;
      push_byte(DirTable[i].data);
    end
    typed_on = 1'b0;
    write_max(24'd1);

    // skipped messages with random content spread over records of random size
    while (items_sent < RandomItems) begin
      repeat ($urandom_range(2, 8)) add_other_msg();
      send_records(1'b0);
      if ($urandom_range(0, 4) == 0) write_max(pick_max());
    end

    ending = ending_e'($urandom_range(0, 7));
    case (ending)
      END_COMPLETE: begin
        e = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0:       m = e;
          1:       m = CertMaxTop;
          default: m = $urandom_range(e, 5000);
        endcase
        write_max(LenW'(m));
        repeat ($urandom_range(0, 2)) add_other_msg();
        add_cert(e + 6, e + 3, e, e);
        send_records($urandom_range(0, 1));
      end
      END_BAD_TYPE: begin
        do a = 8'($urandom_range(0, 255)); while (a == RecTypeHandshake);
        push_byte(a);
        push_byte(TlsVersionByte);
        push_byte(TlsVersionByte);
        push_byte(8'h00);
        push_byte(8'h01);
      end
      END_BAD_VERSION: begin
        do v = 8'($urandom_range(0, 255)); while (v == TlsVersionByte);
        push_byte(RecTypeHandshake);
        if ($urandom_range(0, 1)) begin
          push_byte(v);
          push_byte(TlsVersionByte);
        end else begin
          push_byte(TlsVersionByte);
          push_byte(v);
        end
        push_byte(8'h00);
        push_byte(8'h01);
      end
      END_ZERO_LEN:    push_rec_header(0);
      END_LONG_RECORD: push_rec_header($urandom_range(int'(MaxRecordPayload) + 1, 65535));
      END_SHORT_CERT: begin
        hs_q.push_back(MsgTypeCert);
        hs_q.push_back(8'h00);
        hs_q.push_back(8'h00);
        hs_q.push_back(8'($urandom_range(0, 5)));
        send_records(1'b1);
      end
      END_BAD_LIST: begin
        l = $urandom_range(6, 40);
        case ($urandom_range(0, 2))
          0:       lst = $urandom_range(0, 2);
          1:       lst = l - 3 + $urandom_range(1, 100);
          default: lst = l - 3 - $urandom_range(1, 3);
        endcase
        add_cert(l, lst, 0, $urandom_range(0, 4));
        send_records($urandom_range(0, 1));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            // zero entry length
            write_max(pick_max());
            e = 0;
            lst = 3;
          end
          1: begin
            // entry just above the limit
            m = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 30);
            write_max(LenW'(m));
            e = m + 1;
            lst = e + 3;
          end
          default: begin
            // entry not matching the list
            write_max(CertMaxTop);
            lst = $urandom_range(5, 37);
            e = $urandom_range(0, 1) ? lst - 3 + $urandom_range(1, 5)
                                     : lst - 3 - $urandom_range(1, lst - 3);
          end
        endcase
        add_cert(lst + 3, lst, e, $urandom_range(0, 4));
        send_records($urandom_range(0, 1));
      end
    endcase

    // outcome is sticky: later bytes change nothing
    repeat (20) push_byte(8'($urandom_range(0, 255)));
    s_axis_tvalid <= 1'b0;
    while (status_due_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0 && status_due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
